### hdl/assert_macros.svh
// Assertion macros shared by the selector's modules.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a combinational condition at every clock edge.
`define CSPB_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define CSPB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another one in the next cycle.
`define CSPB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/cspb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspb_pkg
// Types and constants of the closest-sample-per-bin selector.
// ----------------------------------------------------------------------------
package cspb_pkg;

	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned BIN_IDX_W   = 10;
	localparam int unsigned BIN_CNT_W   = 11;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_BINNING_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_TARGET    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_WINDOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_ORIGIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_Z_SPACING = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT     = 3'd5;

	// register reset values
	localparam logic                  RST_BINNING_MODE  = 1'b0;
	localparam logic signed [31:0]    RST_BIN_TARGET    = 32'sd0;
	localparam logic signed [31:0]    RST_AMP_WINDOW    = -32'sd1;
	localparam logic signed [31:0]    RST_Z_ORIGIN      = 32'sd0;
	localparam logic [31:0]           RST_INV_Z_SPACING = 32'd26214;
	localparam logic [BIN_CNT_W-1:0]  RST_BIN_COUNT     = 11'd1024;

	localparam logic OP_OFFER  = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam logic MODE_PHASE     = 1'b0;
	localparam logic MODE_AMPLITUDE = 1'b1;

	// one half in the Q32.32 product
	localparam logic [63:0] PROD_HALF = 64'h0000_0000_8000_0000;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] amplitude;
		logic signed [31:0] phase;
		logic signed [31:0] z_position;
	} request_t;

	typedef struct packed {
		logic                 accepted;
		logic                 out_of_range;
		logic [BIN_IDX_W-1:0] bin_index;
		logic signed [31:0]   min_kept;
		logic signed [31:0]   max_kept;
		logic [BIN_CNT_W-1:0] empty_bins;
	} result_t;

	// one stored bin
	typedef struct packed {
		logic               filled;
		logic [31:0]        distance;
		logic signed [31:0] value;
	} bin_entry_t;

	typedef struct packed {
		logic load_req;
		logic mul;
		logic idx_rd;
		logic rmw;
		logic walk_rd;
		logic clr_wr;
		logic ptr_clr;
		logic ptr_inc;
		logic acc_clr;
		logic emit_report;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic walk_end;
	} ctrl_sts_t;

endpackage

### hdl/cspb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cspb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/cspb_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspb_dpath
// Datapath: configuration registers, bin index and distance arithmetic,
// bin store read-modify-write, report accumulation and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cspb_dpath #(
	parameter int unsigned MAX_BINS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cspb_pkg::request_t                request,
	input  logic                              cfg_we,
	input  logic [cspb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cspb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  cspb_pkg::ctrl_cmd_t               cmd,
	output cspb_pkg::ctrl_sts_t               sts,
	output cspb_pkg::result_t                 result
);
	import cspb_pkg::*;

	localparam int unsigned AW  = $clog2(MAX_BINS);
	localparam int unsigned PW  = AW + 1;
	localparam int unsigned CW  = (PW > BIN_CNT_W) ? PW : BIN_CNT_W;
	localparam int unsigned CAP = (MAX_BINS < 2047) ? MAX_BINS : 2047;

	// configuration
	logic                   mode_q;
	logic signed [31:0]     target_q;
	logic signed [31:0]     window_q;
	logic signed [31:0]     origin_q;
	logic [31:0]            inv_q;
	logic [BIN_CNT_W-1:0]   bcount_q;
	logic [BIN_CNT_W-1:0]   count;

	request_t               req_q;

	// offer pipeline
	logic signed [32:0]     diff;
	logic [32:0]            diff_mag;
	logic signed [31:0]     val;
	logic signed [32:0]     dev;
	logic [32:0]            dev_mag;
	logic [63:0]            prod_s1;
	logic                   neg_s1;
	logic [31:0]            dist_s1;
	logic signed [31:0]     val_s1;
	logic [32:0]            idx_full;
	logic                   inr;
	logic [AW-1:0]          idx_eff;
	logic [AW-1:0]          idx_s2;
	logic                   inr_s2;

	// bin store
	bin_entry_t             rd_entry;
	bin_entry_t             wr_entry;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [AW-1:0]          ram_raddr;
	logic                   closer;
	logic                   take;

	// walk pointer and report accumulators
	logic [PW-1:0]          ptr_q;
	logic                   rd_vld_s1;
	logic                   any_q;
	logic signed [31:0]     lo_q;
	logic signed [31:0]     hi_q;
	logic [BIN_CNT_W-1:0]   used_q;

	result_t                res_q;

	assign count = (bcount_q > BIN_CNT_W'(CAP)) ? BIN_CNT_W'(CAP) : bcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= RST_BINNING_MODE;
			target_q <= RST_BIN_TARGET;
			window_q <= RST_AMP_WINDOW;
			origin_q <= RST_Z_ORIGIN;
			inv_q    <= RST_INV_Z_SPACING;
			bcount_q <= RST_BIN_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BINNING_MODE:  mode_q   <= cfg_data[0];
				CFG_BIN_TARGET:    target_q <= cfg_data;
				CFG_AMP_WINDOW:    window_q <= cfg_data;
				CFG_Z_ORIGIN:      origin_q <= cfg_data;
				CFG_INV_Z_SPACING: inv_q    <= cfg_data;
				CFG_BIN_COUNT:     bcount_q <= cfg_data[BIN_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= request;
		end
	end

	// stage 1: z offset times inverse spacing, and the distance to the target
	assign diff     = {req_q.z_position[31], req_q.z_position} - {origin_q[31], origin_q};
	assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign val      = (mode_q == MODE_AMPLITUDE) ? req_q.amplitude : req_q.phase;
	assign dev      = {val[31], val} - {target_q[31], target_q};
	assign dev_mag  = dev[32] ? 33'(-dev) : 33'(dev);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= 64'(diff_mag[31:0]) * 64'(inv_q);
			neg_s1  <= diff[32];
			dist_s1 <= dev_mag[31:0];
			val_s1  <= val;
		end
	end

	// stage 2: round half up to the bin index, range check, read the bin
	assign idx_full = {1'b0, prod_s1[63:32]} + 33'(prod_s1[31]);
	always_comb begin
		if (neg_s1) begin
			inr     = (prod_s1 <= PROD_HALF) && (count != '0);
			idx_eff = '0;
		end else begin
			inr     = idx_full < 33'(count);
			idx_eff = idx_full[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx_rd) begin
			idx_s2 <= idx_eff;
			inr_s2 <= inr;
		end
	end

	assign ram_raddr = cmd.idx_rd ? idx_eff : ptr_q[AW-1:0];

	// stage 3: compare with the kept record and write back
	always_comb begin
		closer = !rd_entry.filled || (dist_s1 < rd_entry.distance);
		if (mode_q == MODE_AMPLITUDE) begin
			if (window_q[31]) begin
				take = closer;
			end else if (window_q == '0) begin
				take = 1'b0;
			end else begin
				take = (dist_s1 <= 32'(window_q)) && closer;
			end
		end else begin
			take = closer;
		end
		take = take && inr_s2;
	end

	always_comb begin
		wr_entry = '0;
		if (!cmd.clr_wr) begin
			wr_entry.filled   = 1'b1;
			wr_entry.distance = dist_s1;
			wr_entry.value    = val_s1;
		end
	end

	assign ram_we    = cmd.clr_wr || (cmd.rmw && take);
	assign ram_waddr = cmd.clr_wr ? ptr_q[AW-1:0] : idx_s2;

	cspb_ram #(
		.WIDTH ($bits(bin_entry_t)),
		.DEPTH (MAX_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	// walk pointer for the clearing pass and the report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.walk_rd;
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + PW'(1);
			end
		end
	end

	assign sts.clr_last = (ptr_q[AW-1:0] == AW'(MAX_BINS - 1));
	assign sts.walk_end = (CW'(ptr_q) >= CW'(count));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q  <= 1'b0;
			lo_q   <= '0;
			hi_q   <= '0;
			used_q <= '0;
		end else if (cmd.acc_clr) begin
			any_q  <= 1'b0;
			lo_q   <= '0;
			hi_q   <= '0;
			used_q <= '0;
		end else if (rd_vld_s1 && rd_entry.filled) begin
			any_q  <= 1'b1;
			used_q <= used_q + BIN_CNT_W'(1);
			if (!any_q || (rd_entry.value < lo_q)) begin
				lo_q <= rd_entry.value;
			end
			if (!any_q || (rd_entry.value > hi_q)) begin
				hi_q <= rd_entry.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rmw) begin
			res_q <= result_t'{
				accepted:     take,
				out_of_range: !inr_s2,
				bin_index:    inr_s2 ? BIN_IDX_W'(idx_s2) : '0,
				min_kept:     '0,
				max_kept:     '0,
				empty_bins:   '0
			};
		end else if (cmd.emit_report) begin
			res_q <= result_t'{
				accepted:     1'b0,
				out_of_range: 1'b0,
				bin_index:    '0,
				min_kept:     lo_q,
				max_kept:     hi_q,
				empty_bins:   count - used_q
			};
		end
	end

	assign result = res_q;

	`CSPB_ASSERT_IMPL(a_take_in_range, cmd.rmw && take, inr_s2, "bin taken out of range")
	`CSPB_ASSERT_IMPL(a_used_le_count, cmd.emit_report, used_q <= count,
		"more filled bins than bins in use")
	`CSPB_ASSERT_NEXT(a_clear_writes_zero, cmd.clr_wr && cmd.rmw, 1'b0,
		"clearing pass overlaps a bin update")

endmodule

### hdl/cspb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspb_ctrl
// Controller: clearing pass, offer sequence and report walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cspb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 opcode,
	input  cspb_pkg::ctrl_sts_t  sts,
	output logic                 busy,
	output logic                 done,
	output cspb_pkg::ctrl_cmd_t  cmd
);
	import cspb_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_MUL    = 8'b0000_0100,
		S_IDX    = 8'b0000_1000,
		S_RMW    = 8'b0001_0000,
		S_WALK   = 8'b0010_0000,
		S_DRAIN  = 8'b0100_0000,
		S_REPORT = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					if (opcode == OP_REPORT) begin
						cmd.ptr_clr = 1'b1;
						cmd.acc_clr = 1'b1;
						state_d     = S_WALK;
					end else begin
						state_d = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_IDX;
			end
			S_IDX: begin
				cmd.idx_rd = 1'b1;
				state_d    = S_RMW;
			end
			S_RMW: begin
				cmd.rmw = 1'b1;
				state_d = S_IDLE;
			end
			S_WALK: begin
				if (sts.walk_end) begin
					state_d = S_DRAIN;
				end else begin
					cmd.walk_rd = 1'b1;
					cmd.ptr_inc = 1'b1;
				end
			end
			// let the last read land in the accumulators
			S_DRAIN: begin
				state_d = S_REPORT;
			end
			S_REPORT: begin
				cmd.emit_report = 1'b1;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.rmw || cmd.emit_report;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	`CSPB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer left block idle")
	`CSPB_ASSERT_IMPL(a_done_idle, done, state_q == S_IDLE, "result strobe outside idle")
	`CSPB_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")

endmodule

### hdl/closest_sample_per_bin_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_sample_per_bin_selector
// Keeps, for each z bin, the slice record closest to a target value and
// reports the extremes of the kept values and the number of empty bins.
// ----------------------------------------------------------------------------
// After reset the block clears its bin store, one entry a cycle, and keeps
// busy high until the clearing is done; configuration writes are taken
// throughout. An item is taken when start is high and busy is low. An offer
// passes from transfer to the next possible transfer through one multiply
// stage, one index and store read stage, one compare and write-back stage,
// and the result cycle, in which done is high and a new item may already be
// taken. A report walks the bins in use through the single store read port.
// Each result is shown with done for one cycle only and must be captured
// then; the block does not wait for it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module closest_sample_per_bin_selector #(
	parameter int unsigned MAX_BINS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  cspb_pkg::request_t                request,
	output logic                              done,
	output cspb_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [cspb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cspb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cspb_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	cspb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.sts    (sts),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	cspb_dpath #(
		.MAX_BINS (MAX_BINS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

	`CSPB_ASSERT_IMPL(a_accept_excl, done && result.accepted, !result.out_of_range,
		"offer both taken and out of range")

endmodule
